@@ src/angsep_pkg.sv @@
// Package for angular_separation: fixed-point widths, CORDIC arctangent table.
// No dependencies.
package angsep_pkg;

  localparam int unsigned TableLen = 48;
  localparam int unsigned CordW = 36;   // signed Q30 CORDIC datapath with headroom
  localparam int unsigned PhW = 36;     // signed phase accumulator
  localparam int unsigned OutW = 36;
  localparam logic signed [CordW-1:0] GainInvQ30 = 36'sd652032874;
  localparam logic signed [CordW-1:0] OneQ30 = 36'sd1073741824;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [PhW-1:0] phase_t;

  function automatic phase_t atan_phase(input int unsigned idx);
    phase_t r;
    r = '0;
    case (idx)
      0: r = 36'sd536870912;
      1: r = 36'sd316933406;
      2: r = 36'sd167458907;
      3: r = 36'sd85004756;
      4: r = 36'sd42667331;
      5: r = 36'sd21354465;
      6: r = 36'sd10679838;
      7: r = 36'sd5340245;
      8: r = 36'sd2670163;
      9: r = 36'sd1335087;
      10: r = 36'sd667544;
      11: r = 36'sd333772;
      12: r = 36'sd166886;
      13: r = 36'sd83443;
      14: r = 36'sd41722;
      15: r = 36'sd20861;
      16: r = 36'sd10430;
      17: r = 36'sd5215;
      18: r = 36'sd2608;
      19: r = 36'sd1304;
      20: r = 36'sd652;
      21: r = 36'sd326;
      22: r = 36'sd163;
      23: r = 36'sd81;
      24: r = 36'sd41;
      25: r = 36'sd20;
      26: r = 36'sd10;
      27: r = 36'sd5;
      28: r = 36'sd3;
      29: r = 36'sd1;
      30: r = 36'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/angular_separation.sv @@
// Top level of angular_separation: pipelined great-circle angle engine.
// Depends on angsep_pkg.
//
// Takes one position pair per cycle when not stalled and gives one angle per
// pair, in 2^-16 arcsecond units. CORDIC stages are capped at 48. Pipeline:
// a rotation CORDIC (one stage per iteration, three in parallel), three
// Q30 multiply stages, a 31-step pipelined square root, a vectoring CORDIC
// and a two-stage output scale. A stall freezes the whole pipeline; valid bits
// travel with each item.
module angular_separation #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] ra_first_i,
  input  logic signed [31:0] dec_first_i,
  input  logic [31:0] ra_second_i,
  input  logic signed [31:0] dec_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [35:0] separation_arcsec_o
);

  localparam int unsigned NS = (CORDIC_STAGES > 48) ? 48 : CORDIC_STAGES;
  localparam int unsigned SqSteps = 31;
  // stages: 1 prep, NS rotation, 1 flip, 3 mul, 1 clamp/square, SqSteps sqrt,
  // 1 vect prep, NS vect, 1 clamp/mul, 1 out
  localparam int unsigned Lat = 2 * NS + SqSteps + 9;

  logic adv;
  logic [Lat-1:0] vld_q;

  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // ---------------- rotation CORDIC, three lanes ----------------
  logic [2:0][31:0] ph_in;
  assign ph_in[0] = dec_first_i;
  assign ph_in[1] = dec_second_i;
  assign ph_in[2] = ra_first_i - ra_second_i;

  angsep_pkg::cord_t  rx_q [NS+1][3];
  angsep_pkg::cord_t  ry_q [NS+1][3];
  angsep_pkg::phase_t rz_q [NS+1][3];
  logic [2:0]         fl_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        angsep_pkg::phase_t z;
        logic f;
        z = angsep_pkg::phase_t'($signed(ph_in[l]));
        f = 1'b0;
        if (z > angsep_pkg::OneQ30) begin
          z = z - 36'sd2147483648;
          f = 1'b1;
        end else if (z < -angsep_pkg::OneQ30) begin
          z = z + 36'sd2147483648;
          f = 1'b1;
        end
        fl_q[0][l] <= f;
        rz_q[0][l] <= z;
        rx_q[0][l] <= angsep_pkg::GainInvQ30;
        ry_q[0][l] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        fl_q[i+1] <= fl_q[i];
        for (int l = 0; l < 3; l++) begin
          if (rz_q[i][l] >= 0) begin
            rx_q[i+1][l] <= rx_q[i][l] - (ry_q[i][l] >>> i);
            ry_q[i+1][l] <= ry_q[i][l] + (rx_q[i][l] >>> i);
            rz_q[i+1][l] <= rz_q[i][l] - angsep_pkg::atan_phase(i);
          end else begin
            rx_q[i+1][l] <= rx_q[i][l] + (ry_q[i][l] >>> i);
            ry_q[i+1][l] <= ry_q[i][l] - (rx_q[i][l] >>> i);
            rz_q[i+1][l] <= rz_q[i][l] + angsep_pkg::atan_phase(i);
          end
        end
      end
    end
  end

  // ---------------- sign fix, products ----------------
  angsep_pkg::cord_t c1_q, s1_q, c2_q, s2_q, cr_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= fl_q[NS][0] ? -rx_q[NS][0] : rx_q[NS][0];
      s1_q <= fl_q[NS][0] ? -ry_q[NS][0] : ry_q[NS][0];
      c2_q <= fl_q[NS][1] ? -rx_q[NS][1] : rx_q[NS][1];
      s2_q <= fl_q[NS][1] ? -ry_q[NS][1] : ry_q[NS][1];
      cr_q <= fl_q[NS][2] ? -rx_q[NS][2] : rx_q[NS][2];
    end
  end

  // operands stay within about +-2^30, so 32 signed bits carry them
  function automatic angsep_pkg::cord_t mulq30(angsep_pkg::cord_t a, angsep_pkg::cord_t b);
    logic signed [31:0] an;
    logic signed [31:0] bn;
    logic signed [63:0] p;
    an = a[31:0];
    bn = b[31:0];
    p = 64'(an) * 64'(bn) + 64'sd536870912;
    return angsep_pkg::cord_t'(p >>> 30);
  endfunction

  angsep_pkg::cord_t cc_q, ss_q, cr2_q, ccc_q, ss2_q, d_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cc_q  <= mulq30(c1_q, c2_q);
      ss_q  <= mulq30(s1_q, s2_q);
      cr2_q <= cr_q;
      ccc_q <= mulq30(cc_q, cr2_q);
      ss2_q <= ss_q;
      d_q   <= ccc_q + ss2_q;
    end
  end

  // clamp and form 2^60 - d^2
  logic signed [31:0] dc_q;
  logic [60:0] rad_q;
  always_ff @(posedge clk_i) begin
    angsep_pkg::cord_t dcl;
    angsep_pkg::cord_t dab;
    logic [30:0] mag;
    logic [61:0] sq;
    if (adv) begin
      dcl = d_q;
      if (dcl > angsep_pkg::OneQ30) dcl = angsep_pkg::OneQ30;
      if (dcl < -angsep_pkg::OneQ30) dcl = -angsep_pkg::OneQ30;
      dab = dcl[31] ? -dcl : dcl;
      mag = dab[30:0];
      sq = 62'(mag) * 62'(mag);
      dc_q  <= 32'(dcl);
      rad_q <= 61'(62'h1000_0000_0000_0000 - sq);
    end
  end

  // ---------------- pipelined square root, one result bit per stage ----------------
  logic [60:0] sv_q [SqSteps+1];
  logic [30:0] sr_q [SqSteps+1];
  logic signed [31:0] sd_q [SqSteps+1];
  always_comb begin
    sv_q[0] = rad_q;
    sr_q[0] = '0;
    sd_q[0] = dc_q;
  end
  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    localparam int unsigned B = SqSteps - 1 - k;
    always_ff @(posedge clk_i) begin
      logic [61:0] trial;
      if (adv) begin
        trial = (62'(sr_q[k]) << (B + 1)) + (62'd1 << (2 * B));
        sd_q[k+1] <= sd_q[k];
        if (62'(sv_q[k]) >= trial) begin
          sv_q[k+1] <= 61'(62'(sv_q[k]) - trial);
          sr_q[k+1] <= sr_q[k] | (31'd1 << B);
        end else begin
          sv_q[k+1] <= sv_q[k];
          sr_q[k+1] <= sr_q[k];
        end
      end
    end
  end

  // ---------------- vectoring CORDIC ----------------
  angsep_pkg::cord_t  vx_q [NS+1];
  angsep_pkg::cord_t  vy_q [NS+1];
  angsep_pkg::phase_t vz_q [NS+1];
  always_ff @(posedge clk_i) begin
    angsep_pkg::cord_t dd, ss;
    if (adv) begin
      dd = angsep_pkg::cord_t'(sd_q[SqSteps]);
      ss = angsep_pkg::cord_t'({1'b0, sr_q[SqSteps]});
      if (dd < 0) begin
        vx_q[0] <= ss;
        vy_q[0] <= -dd;
        vz_q[0] <= angsep_pkg::OneQ30;
      end else begin
        vx_q[0] <= dd;
        vy_q[0] <= ss;
        vz_q[0] <= '0;
      end
    end
  end
  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (vy_q[i] >= 0) begin
          vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] + angsep_pkg::atan_phase(i);
        end else begin
          vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] - angsep_pkg::atan_phase(i);
        end
      end
    end
  end

  // ---------------- clamp and scale ----------------
  logic [45:0] prod_q;
  logic [35:0] out_q;
  always_ff @(posedge clk_i) begin
    logic [31:0] pc;
    if (adv) begin
      if (vz_q[NS] < 0) pc = '0;
      else if (vz_q[NS] > 36'sd2147483648) pc = 32'h8000_0000;
      else pc = 32'(vz_q[NS]);
      prod_q <= 46'(pc) * 46'd10125 + 46'd256;
      out_q  <= 36'(prod_q >> 9);
    end
  end
  assign separation_arcsec_o = out_q;

endmodule

@@ src/angular_separation_chk.sv @@
// Port checker for angular_separation, bound to the top level.
// No dependencies.
module angular_separation_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [35:0] separation_arcsec_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(separation_arcsec_o))
    else $error("result changed under stall");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> separation_arcsec_o <= 36'd42467328000)
    else $error("angle out of range");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
endmodule

bind angular_separation angular_separation_chk u_chk (.*);

@@ sim/tb_top.sv @@
// Testbench for angular_separation: random and directed position pairs, with a
// bit-exact CORDIC predictor in a scoreboard class. Depends on angsep_pkg.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned Stages = 32;
  localparam int unsigned UsedStages =
    (Stages < angsep_pkg::TableLen) ? Stages : angsep_pkg::TableLen;
  localparam int unsigned Latency = 2 * UsedStages + 40;
  localparam int unsigned NumRandom = 1830;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned NumDirected = 13;

  typedef struct packed {
    logic [31:0] ra_a;
    logic [31:0] dec_a;
    logic [31:0] ra_b;
    logic [31:0] dec_b;
  } pair_t;

  class separation_scoreboard;
    logic [35:0] expected_q[$];
    int unsigned mismatches;

    function automatic longint asr(longint v, int unsigned n);
      return v >>> n;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
      return asr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic void rotate(logic [31:0] ph, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = longint'(ph);
      x = angsep_pkg::GainInvQ30;
      y = 0;
      flip = 0;
      if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
      if (z > angsep_pkg::OneQ30) begin
        z -= (64'sd1 <<< 31);
        flip = 1;
      end else if (z < -angsep_pkg::OneQ30) begin
        z += (64'sd1 <<< 31);
        flip = 1;
      end
      for (int unsigned i = 0; i < UsedStages; i++) begin
        if (z >= 0) begin
          nx = x - asr(y, i);
          y = y + asr(x, i);
          z -= longint'(angsep_pkg::atan_phase(i));
        end else begin
          nx = x + asr(y, i);
          y = y - asr(x, i);
          z += longint'(angsep_pkg::atan_phase(i));
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function automatic longint isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function automatic longint arc_cos(longint d);
      longint s, x, y, z, nx;
      s = isqrt(longint'(64'sd1 <<< 60) - d * d);
      x = d;
      y = s;
      z = 0;
      if (x < 0) begin
        x = s;
        y = -d;
        z = angsep_pkg::OneQ30;
      end
      for (int unsigned i = 0; i < UsedStages; i++) begin
        if (y >= 0) begin
          nx = x + asr(y, i);
          y = y - asr(x, i);
          z += longint'(angsep_pkg::atan_phase(i));
        end else begin
          nx = x - asr(y, i);
          y = y + asr(x, i);
          z -= longint'(angsep_pkg::atan_phase(i));
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 <<< 31)) z = 64'sd1 <<< 31;
      return z;
    endfunction

    function automatic void note_pair(pair_t p);
      longint c1, s1, c2, s2, cr, sr, d, ph;
      longint unsigned scaled;
      rotate(p.dec_a, c1, s1);
      rotate(p.dec_b, c2, s2);
      rotate(p.ra_a - p.ra_b, cr, sr);
      d = mul_q30(mul_q30(c1, c2), cr) + mul_q30(s1, s2);
      if (d > angsep_pkg::OneQ30) d = angsep_pkg::OneQ30;
      if (d < -angsep_pkg::OneQ30) d = -angsep_pkg::OneQ30;
      ph = arc_cos(d);
      scaled = (longint'(ph) * 10125 + 256) >> 9;
      expected_q = {expected_q, scaled[35:0]};
    endfunction

    function automatic void check_separation(logic [35:0] got);
      logic [35:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("separation mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [31:0] ra_first_i = '0;
  logic signed [31:0] dec_first_i = '0;
  logic [31:0] ra_second_i = '0;
  logic signed [31:0] dec_second_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [35:0] separation_arcsec_o;

  separation_scoreboard board = new();
  int unsigned idle_cycles = 0;
  bit stall_pattern_on = 1;

  angular_separation #(.CORDIC_STAGES(Stages)) u_top (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // receiver: stretches of random length with a one-in-four stall chance, and stall-free stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_pattern_on <= ~stall_pattern_on;
    out_stall_i <= stall_pattern_on ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        board.note_pair({ra_first_i, dec_first_i, ra_second_i, dec_second_i});
      if (out_valid_o && !out_stall_i) board.check_separation(separation_arcsec_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_dec();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'sh4000_0000;
      2: return -32'sh4000_0000;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  task automatic send_pair(pair_t p);
    in_valid_i <= 1;
    ra_first_i <= p.ra_a;
    dec_first_i <= p.dec_a;
    ra_second_i <= p.ra_b;
    dec_second_i <= p.dec_b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic gap(int unsigned n);
    if (n == 0) return;
    in_valid_i <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    pair_t p;
    pair_t directed [NumDirected];
    int unsigned burst;
    int unsigned k;
    bit mid_drained;
    directed = '{
      '{32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd0, 32'h4000_0000, 32'd0, 32'hC000_0000},
      '{32'd0, 32'h4000_0000, 32'd12345, 32'h4000_0000},
      '{32'd0, 32'd0, 32'h8000_0000, 32'd0},
      '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0},
      '{32'h4000_0000, 32'd0, 32'd0, 32'd0},
      '{32'd0, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000},
      '{32'd0, 32'h6000_0000, 32'h1000_0000, 32'hA000_0000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1},
      '{32'd1, 32'd0, 32'd0, 32'd0},
      '{32'd0, 32'h2000_0000, 32'h8000_0000, 32'hE000_0000},
      '{32'h8000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h3FFF_FFFF},
      '{32'h1234_5678, 32'h0ABC_DEF0, 32'h1234_5679, 32'h0ABC_DEF0}
    };
    mid_drained = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (directed[i]) send_pair(directed[i]);
    drain();
    k = 0;
    while (k < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int unsigned j = 0; j < burst && k < NumRandom; j++, k++) begin
        p.ra_a = $urandom();
        p.dec_a = rand_dec();
        case ($urandom_range(0, 3))
          0: p.ra_b = p.ra_a + $urandom_range(0, 15) - 8;
          1: p.ra_b = p.ra_a + 32'h8000_0000 + $urandom_range(0, 15) - 8;
          default: p.ra_b = $urandom();
        endcase
        p.dec_b = ($urandom_range(0, 5) == 0) ? p.dec_a + $urandom_range(0, 3)
                                                 : rand_dec();
        if ($urandom_range(0, 9) == 0) p.dec_b = -p.dec_a;
        send_pair(p);
      end
      if (!mid_drained && k >= NumRandom / 2) begin
        mid_drained = 1;
        drain();
      end
      gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
    end
    drain();
    repeat (Latency + 20) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ angular_separation.f @@
src/angsep_pkg.sv
src/angular_separation.sv
src/angular_separation_chk.sv
sim/tb_top.sv
